/* design/cgl_pkg.sv */
// shared constants and types for the colour gradient lookup
// no dependencies
package cgl_pkg;
   localparam int MAX_POINTS = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = 5;
   localparam int LOC_W      = 17;
   localparam logic [LOC_W-1:0] LOC_ONE = 17'd65536;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_ADD    = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [LOC_W-1:0] loc;
      logic [31:0]      color;
   } stop_type;
endpackage

/* design/color_gradient_lookup.sv */
// colour gradient lookup: sorted stop table in one synchronous memory
// depends on cgl_pkg
//
// Input channel req_*: one beat per item, opcode 0 looks up a colour,
// 1 adds a stop (location and RGBA), 2 clears the table. Result channel
// rsp_*: exactly one beat per item with the colour (zero unless lookup),
// the table-full flag and the stop count after the item.
// One item is worked at a time; req_stall is high until the result beat
// has been taken. A lookup walks the table one memory read a cycle, then
// a multiply step, a bit-serial divide and a correction step follow.
// An add walks down from the top entry, moving one entry up per cycle.
// The walk is set by the single memory read port.
// Reset empties the table (count to zero); memory contents are not cleared.
// While rsp_stall is high the result beat holds and no new item is taken.
module color_gradient_lookup (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_opcode,
   input  logic [cgl_pkg::LOC_W-1:0] req_location,
   input  logic [7:0]                req_in_red,
   input  logic [7:0]                req_in_green,
   input  logic [7:0]                req_in_blue,
   input  logic [7:0]                req_in_alpha,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_out_red,
   output logic [7:0]                rsp_out_green,
   output logic [7:0]                rsp_out_blue,
   output logic [7:0]                rsp_out_alpha,
   output logic                      rsp_status,
   output logic [cgl_pkg::CNT_W-1:0] rsp_stop_count
);
   import cgl_pkg::*;

   typedef enum logic [2:0] {
      IDLE, LK_SCAN, LK_MUL, LK_DIV, LK_FIX, INS_SCAN, INS_LAST, RESP
   } state_type;

   state_type            state_ff;
   stop_type             mem [MAX_POINTS];
   stop_type             rd_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   stop_type             wr_data;

   logic [CNT_W-1:0]     cnt_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [LOC_W-1:0]     loc_ff;
   logic [31:0]          new_col_ff;
   stop_type             prev_ff;
   logic [LOC_W-1:0]     d_ff;
   logic [LOC_W-1:0]     s_ff;
   logic [3:0][7:0]      ca_ff;
   logic [3:0][7:0]      cb_ff;
   logic [3:0]           neg_ff;
   logic [3:0][LOC_W:0]  rem_ff;
   logic [3:0][7:0]      low_ff;
   logic [3:0][7:0]      q_ff;
   logic [2:0]           step_ff;
   logic [31:0]          out_col_ff;
   logic                 status_ff;

   logic [LOC_W-1:0]     loc_sat;
   logic                 accept;
   logic                 last_idx;

   assign loc_sat   = (req_location > LOC_ONE) ? LOC_ONE : req_location;
   assign accept    = req_valid && (state_ff == IDLE);
   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = (state_ff == RESP);
   assign last_idx  = ({1'b0, idx_ff} == cnt_ff - CNT_W'(1));

   always_comb begin
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = rd_ff;
      case (state_ff)
         IDLE: begin
            if (req_opcode == OP_ADD) begin
               rd_addr = IDX_W'(cnt_ff - CNT_W'(1));
            end
            if (accept && req_opcode == OP_ADD && cnt_ff == '0) begin
               wr_en   = 1'b1;
               wr_data = '{loc: loc_sat,
                           color: {req_in_alpha, req_in_blue, req_in_green, req_in_red}};
            end
         end
         LK_SCAN: rd_addr = idx_ff + IDX_W'(1);
         INS_SCAN: begin
            rd_addr = idx_ff - IDX_W'(1);
            wr_en   = 1'b1;
            wr_addr = idx_ff + IDX_W'(1);
            if (rd_ff.loc <= loc_ff) begin
               wr_data = '{loc: loc_ff, color: new_col_ff};
            end
         end
         INS_LAST: begin
            wr_en   = 1'b1;
            wr_data = '{loc: loc_ff, color: new_col_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         cnt_ff   <= '0;
      end else begin
         case (state_ff)
            IDLE: begin
               if (accept) begin
                  loc_ff     <= loc_sat;
                  new_col_ff <= {req_in_alpha, req_in_blue, req_in_green, req_in_red};
                  out_col_ff <= '0;
                  status_ff  <= 1'b0;
                  idx_ff     <= '0;
                  state_ff   <= RESP;
                  case (req_opcode)
                     OP_LOOKUP: begin
                        if (cnt_ff == '0) begin
                           out_col_ff <= '1;
                        end else begin
                           state_ff <= LK_SCAN;
                        end
                     end
                     OP_ADD: begin
                        if ({27'd0, cnt_ff} >= MAX_POINTS) begin
                           status_ff <= 1'b1;
                        end else if (cnt_ff == '0) begin
                           cnt_ff <= CNT_W'(1);
                        end else begin
                           idx_ff   <= IDX_W'(cnt_ff - CNT_W'(1));
                           state_ff <= INS_SCAN;
                        end
                     end
                     OP_CLEAR: cnt_ff <= '0;
                     default: ;
                  endcase
               end
            end
            LK_SCAN: begin
               prev_ff <= rd_ff;
               if (idx_ff == '0 && loc_ff <= rd_ff.loc) begin
                  out_col_ff <= rd_ff.color;
                  state_ff   <= RESP;
               end else if (idx_ff != '0 && loc_ff < rd_ff.loc) begin
                  d_ff     <= loc_ff - prev_ff.loc;
                  s_ff     <= rd_ff.loc - prev_ff.loc;
                  ca_ff    <= prev_ff.color;
                  cb_ff    <= rd_ff.color;
                  state_ff <= LK_MUL;
               end else if (last_idx) begin
                  out_col_ff <= rd_ff.color;
                  state_ff   <= RESP;
               end else begin
                  idx_ff <= idx_ff + IDX_W'(1);
               end
            end
            LK_MUL: begin
               for (int k = 0; k < 4; k++) begin
                  logic [7:0]  diff;
                  logic [24:0] prod;
                  diff = (cb_ff[k] >= ca_ff[k]) ? cb_ff[k] - ca_ff[k] : ca_ff[k] - cb_ff[k];
                  prod = 25'(diff) * 25'(d_ff);
                  neg_ff[k] <= (cb_ff[k] < ca_ff[k]);
                  rem_ff[k] <= {1'b0, prod[24:8]};
                  low_ff[k] <= prod[7:0];
                  q_ff[k]   <= '0;
               end
               step_ff  <= '0;
               state_ff <= LK_DIV;
            end
            LK_DIV: begin
               for (int k = 0; k < 4; k++) begin
                  logic [LOC_W:0] t;
                  t = {rem_ff[k][LOC_W-1:0], low_ff[k][7]};
                  if (t >= {1'b0, s_ff}) begin
                     rem_ff[k] <= t - {1'b0, s_ff};
                     q_ff[k]   <= {q_ff[k][6:0], 1'b1};
                  end else begin
                     rem_ff[k] <= t;
                     q_ff[k]   <= {q_ff[k][6:0], 1'b0};
                  end
                  low_ff[k] <= {low_ff[k][6:0], 1'b0};
               end
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'd7) begin
                  state_ff <= LK_FIX;
               end
            end
            LK_FIX: begin
               for (int k = 0; k < 4; k++) begin
                  logic [8:0] qc;
                  logic [8:0] r;
                  qc = {1'b0, q_ff[k]} + ((rem_ff[k] != '0) ? 9'd1 : 9'd0);
                  r  = neg_ff[k] ? {1'b0, ca_ff[k]} - qc : {1'b0, ca_ff[k]} + {1'b0, q_ff[k]};
                  out_col_ff[8*k +: 8] <= r[7:0];
               end
               state_ff <= RESP;
            end
            INS_SCAN: begin
               if (rd_ff.loc > loc_ff) begin
                  if (idx_ff == '0) begin
                     state_ff <= INS_LAST;
                  end else begin
                     idx_ff <= idx_ff - IDX_W'(1);
                  end
               end else begin
                  cnt_ff   <= cnt_ff + CNT_W'(1);
                  state_ff <= RESP;
               end
            end
            INS_LAST: begin
               cnt_ff   <= cnt_ff + CNT_W'(1);
               state_ff <= RESP;
            end
            RESP: begin
               if (!rsp_stall) begin
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_out_red    = out_col_ff[7:0];
   assign rsp_out_green  = out_col_ff[15:8];
   assign rsp_out_blue   = out_col_ff[23:16];
   assign rsp_out_alpha  = out_col_ff[31:24];
   assign rsp_status     = status_ff;
   assign rsp_stop_count = cnt_ff;
endmodule

/* verif/cgl_checker.sv */
// checker for the colour gradient lookup: watches both channels, predicts
// each result from its own copy of the stop table and compares; uses cgl_pkg
`timescale 1ns / 1ps
module cgl_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [1:0]                req_opcode,
   input  logic [cgl_pkg::LOC_W-1:0] req_location,
   input  logic [7:0]                req_in_red,
   input  logic [7:0]                req_in_green,
   input  logic [7:0]                req_in_blue,
   input  logic [7:0]                req_in_alpha,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [7:0]                rsp_out_red,
   input  logic [7:0]                rsp_out_green,
   input  logic [7:0]                rsp_out_blue,
   input  logic [7:0]                rsp_out_alpha,
   input  logic                      rsp_status,
   input  logic [cgl_pkg::CNT_W-1:0] rsp_stop_count,
   output int                        fail_count,
   output int                        pending_colours
);
   import cgl_pkg::*;

   typedef struct packed {
      logic [31:0]      rgba;
      logic             full;
      logic [CNT_W-1:0] held;
   } colour_beat_type;

   logic [LOC_W-1:0] ramp_loc [MAX_POINTS];
   logic [31:0]      ramp_rgba [MAX_POINTS];
   int               ramp_len;
   colour_beat_type  expected_colours [$];

   function automatic logic [7:0] blend(input int ca, input int cb, input int d, input int s);
      if (cb >= ca) return 8'(ca + ((cb - ca) * d) / s);
      return 8'(ca - (((ca - cb) * d + s - 1) / s));
   endfunction

   function automatic logic [31:0] ramp_colour(input int l);
      int a;
      int d;
      int s;
      logic [31:0] c;
      if (ramp_len == 0) return 32'hFFFF_FFFF;
      if (l <= ramp_loc[0]) return ramp_rgba[0];
      if (l >= ramp_loc[ramp_len-1]) return ramp_rgba[ramp_len-1];
      a = 0;
      for (int i = 0; i < ramp_len; i++) if (l >= ramp_loc[i]) a = i;
      d = l - ramp_loc[a];
      s = ramp_loc[a+1] - ramp_loc[a];
      if (s == 0) return ramp_rgba[a];
      for (int k = 0; k < 4; k++)
         c[8*k +: 8] = blend(ramp_rgba[a][8*k +: 8], ramp_rgba[a+1][8*k +: 8], d, s);
      return c;
   endfunction

   task automatic predict_beat();
      colour_beat_type e;
      int l;
      int p;
      e = '0;
      l = (req_location > LOC_ONE) ? LOC_ONE : req_location;
      if (req_opcode == OP_LOOKUP) begin
         e.rgba = ramp_colour(l);
      end else if (req_opcode == OP_ADD) begin
         if (ramp_len >= MAX_POINTS) begin
            e.full = 1'b1;
         end else begin
            p = 0;
            while (p < ramp_len && ramp_loc[p] <= l) p++;
            for (int i = ramp_len; i > p; i--) begin
               ramp_loc[i]  = ramp_loc[i-1];
               ramp_rgba[i] = ramp_rgba[i-1];
            end
            ramp_loc[p]  = LOC_W'(l);
            ramp_rgba[p] = {req_in_alpha, req_in_blue, req_in_green, req_in_red};
            ramp_len++;
         end
      end else if (req_opcode == OP_CLEAR) begin
         ramp_len = 0;
      end
      e.held = CNT_W'(ramp_len);
      expected_colours.push_back(e);
   endtask

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   task automatic compare_beat();
      colour_beat_type e;
      if (expected_colours.size() == 0) begin
         report("unexpected result beat", 1, 0);
         return;
      end
      e = expected_colours.pop_front();
      if (rsp_out_red   !== e.rgba[7:0])   report("red",   rsp_out_red,   e.rgba[7:0]);
      if (rsp_out_green !== e.rgba[15:8])  report("green", rsp_out_green, e.rgba[15:8]);
      if (rsp_out_blue  !== e.rgba[23:16]) report("blue",  rsp_out_blue,  e.rgba[23:16]);
      if (rsp_out_alpha !== e.rgba[31:24]) report("alpha", rsp_out_alpha, e.rgba[31:24]);
      if (rsp_status    !== e.full)        report("status", rsp_status, e.full);
      if (rsp_stop_count !== e.held)       report("stop count", rsp_stop_count, e.held);
   endtask

   initial begin
      fail_count = 0;
      ramp_len = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) compare_beat();
         if (req_valid && !req_stall) predict_beat();
      end
      pending_colours <= expected_colours.size();
   end
endmodule

/* verif/testbench.sv */
// stimulus and verdict for the colour gradient lookup
// depends on cgl_pkg, color_gradient_lookup and cgl_checker
`timescale 1ns / 1ps
module testbench;
   import cgl_pkg::*;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_opcode;
   logic [LOC_W-1:0]     req_location;
   logic [7:0]           req_in_red;
   logic [7:0]           req_in_green;
   logic [7:0]           req_in_blue;
   logic [7:0]           req_in_alpha;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [7:0]           rsp_out_red;
   logic [7:0]           rsp_out_green;
   logic [7:0]           rsp_out_blue;
   logic [7:0]           rsp_out_alpha;
   logic                 rsp_status;
   logic [CNT_W-1:0]     rsp_stop_count;
   int                   fail_count;
   int                   pending_colours;
   int                   idle_cycles;
   bit                   long_hold;

   color_gradient_lookup dut (.*);
   cgl_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   task automatic send_beat(input logic [1:0] op, input int l, input logic [31:0] c);
      int gap;
      gap = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_location <= LOC_W'(l);
      {req_in_alpha, req_in_blue, req_in_green, req_in_red} <= c;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_colours == 0);
   endtask

   task automatic fill_ramp(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 4) == 0)
            send_beat(OP_ADD, 16384 * $urandom_range(0, 4), $urandom);
         else
            send_beat(OP_ADD, $urandom_range(0, 65536), $urandom);
      end
   endtask

   initial begin
      int sent;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_LOOKUP;
      req_location = '0;
      {req_in_alpha, req_in_blue, req_in_green, req_in_red} = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: empty, single stop, equal locations, extremes, full table
      send_beat(OP_LOOKUP, 0, '0);
      send_beat(OP_UNUSED, 131071, 32'hFFFF_FFFF);
      send_beat(OP_ADD, 131071, 32'hFFFF_FFFF);
      send_beat(OP_LOOKUP, 0, '0);
      send_beat(OP_LOOKUP, 65536, '0);
      send_beat(OP_ADD, 0, 32'h0000_0000);
      send_beat(OP_ADD, 0, 32'h8040_20FF);
      send_beat(OP_LOOKUP, 0, '0);
      send_beat(OP_LOOKUP, 32768, '0);
      send_beat(OP_LOOKUP, 131071, '0);
      send_beat(OP_CLEAR, 131071, 32'hFFFF_FFFF);
      send_beat(OP_ADD, 0, 32'h00FF_00FF);
      send_beat(OP_ADD, 65536, 32'hFF00_FF00);
      send_beat(OP_LOOKUP, 1, '0);
      send_beat(OP_LOOKUP, 65535, '0);
      send_beat(OP_LOOKUP, 43690, '0);
      fill_ramp(15);
      send_beat(OP_LOOKUP, 30000, '0);
      drain();
      sent = 0;
      while (sent < 1850) begin
         int r;
         r = $urandom_range(0, 99);
         if (r < 6) begin
            send_beat(OP_CLEAR, $urandom_range(0, 131071), $urandom);
         end else if (r < 30) begin
            send_beat(OP_ADD, $urandom_range(0, 65536), $urandom);
         end else if (r < 33) begin
            send_beat(2'($urandom_range(0, 3)), $urandom_range(0, 131071), $urandom);
         end else begin
            send_beat(OP_LOOKUP, $urandom_range(0, 65536), '0);
         end
         sent++;
         if (sent == 900) begin
            drain();
         end
      end
      drain();
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("color_gradient_lookup verification clean");
      else
         $display("color_gradient_lookup verification failed");
      $finish;
   end

   // receiver side, with at most one long hold-off at a random point
   initial begin
      int wait_cycles;
      rsp_stall = 1'b0;
      long_hold = 1'b0;
      @(negedge reset);
      forever begin
         if (!long_hold && pending_colours > 0 && $urandom_range(0, 99) == 0) begin
            long_hold = 1'b1;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
         end
         wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
         rsp_stall <= (wait_cycles != 0);
         repeat (wait_cycles) @(posedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
         $display("color_gradient_lookup verification failed");
         $finish;
      end
   end
endmodule
